[sv/alternating_bit_arq_sender_top_assert.svh]
// Assertion macros for the alternating-bit ARQ sender.
// Used by alternating_bit_arq_sender_top; no other dependencies.
`ifndef ALTERNATING_BIT_ARQ_SENDER_TOP_ASSERT_SVH
`define ALTERNATING_BIT_ARQ_SENDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ABAS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ABAS_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ABAS_ASSERT(name, clk, rst_n, prop, msg)
`define ABAS_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

[sv/abas_pkg.sv]
// Shared types, codes and checksum helper for the alternating-bit ARQ sender.
// No dependencies.
`default_nettype none
package abas_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0] PAD_BYTE = 8'h30;

  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SEND    = 3'd1;
  localparam logic [2:0] EV_RESEND  = 3'd2;
  localparam logic [2:0] EV_ACCEPT  = 3'd3;
  localparam logic [2:0] EV_DISCARD = 3'd4;
  localparam logic [2:0] EV_BUSY    = 3'd5;
  localparam logic [2:0] EV_STALE   = 3'd6;

  localparam logic REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data_word;
    logic        is_last;
    logic        odd_last;
    logic        ack_seq;
    logic [39:0] ack_text;
    logic [2:0]  ack_text_len;
    logic [15:0] ack_checksum;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        seq_bit;
    logic [15:0] packet_checksum;
  } result_t;

  typedef struct packed {
    logic waiting;
    logic pending_seq;
  } status_t;

  // one's complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage
`default_nettype wire

[sv/abas_ack_check.sv]
// Ack text checksum check: pads odd text with '0', sums words, compares.
// Depends on abas_pkg.
`default_nettype none
module abas_ack_check (
  input  wire logic [39:0] ack_text_i,
  input  wire logic [2:0]  ack_text_len_i,
  input  wire logic [15:0] ack_checksum_i,
  output logic             ack_ok_o
);

  logic [2:0]  len_sat;
  logic [2:0]  shift_bytes;
  logic [39:0] aligned;
  logic [7:0]  bytes [6];
  logic [15:0] sum;

  always_comb begin
    if (ack_text_len_i inside {[3'd6:3'd7]}) begin
      len_sat = 3'd5;
    end else begin
      len_sat = ack_text_len_i;
    end
    shift_bytes = 3'd5 - len_sat;
    aligned = ack_text_i << {shift_bytes, 3'b000};
    for (int i = 0; i < 5; i++) begin
      bytes[i] = aligned[39-8*i -: 8];
    end
    bytes[5] = 8'h00;
    for (int i = 0; i < 6; i++) begin
      if (len_sat[0] && (len_sat == 3'(i))) begin
        bytes[i] = abas_pkg::PAD_BYTE;
      end
    end
    sum = abas_pkg::oc_add(abas_pkg::oc_add({bytes[0], bytes[1]}, {bytes[2], bytes[3]}),
                           {bytes[4], bytes[5]});
    ack_ok_o = ((~sum) == ack_checksum_i);
  end

endmodule
`default_nettype wire

[sv/abas_core.sv]
// Sender state and per-item decision: running sum, sequence bit, wait and timer.
// Depends on abas_pkg and abas_ack_check.
`default_nettype none
module abas_core #(
  parameter int unsigned TimeoutW = abas_pkg::TimeoutW
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire abas_pkg::item_t       item_i,
  input  wire logic [TimeoutW-1:0]   timeout_i,
  output abas_pkg::result_t          result_o,
  output abas_pkg::status_t          status_o
);

  logic [15:0]         running_sum_q, running_sum_d;
  logic                next_seq_q, next_seq_d;
  logic                waiting_q, waiting_d;
  logic                pending_seq_q, pending_seq_d;
  logic [15:0]         held_checksum_q, held_checksum_d;
  logic [TimeoutW-1:0] timer_q, timer_d;
  logic                ack_ok;
  logic [15:0]         word;
  logic [15:0]         sum;

  abas_ack_check u_ack_check (
    .ack_text_i     (item_i.ack_text),
    .ack_text_len_i (item_i.ack_text_len),
    .ack_checksum_i (item_i.ack_checksum),
    .ack_ok_o       (ack_ok)
  );

  always_comb begin
    running_sum_d   = running_sum_q;
    next_seq_d      = next_seq_q;
    waiting_d       = waiting_q;
    pending_seq_d   = pending_seq_q;
    held_checksum_d = held_checksum_q;
    timer_d         = timer_q;
    result_o        = '0;
    result_o.event_res = abas_pkg::EV_NONE;
    word = item_i.data_word;
    if (item_i.is_last && item_i.odd_last) begin
      word = {item_i.data_word[15:8], abas_pkg::PAD_BYTE};
    end
    sum = abas_pkg::oc_add(running_sum_q, word);
    case (item_i.kind)
      abas_pkg::KIND_WORD: begin
        if (waiting_q) begin
          result_o.event_res = abas_pkg::EV_BUSY;
        end else if (item_i.is_last) begin
          result_o.event_res       = abas_pkg::EV_SEND;
          result_o.seq_bit         = next_seq_q;
          result_o.packet_checksum = ~sum;
          pending_seq_d   = next_seq_q;
          next_seq_d      = ~next_seq_q;
          held_checksum_d = ~sum;
          waiting_d       = 1'b1;
          timer_d         = timeout_i;
          running_sum_d   = '0;
        end else begin
          running_sum_d = sum;
        end
      end
      abas_pkg::KIND_ACK: begin
        result_o.seq_bit = item_i.ack_seq;
        if (!waiting_q) begin
          result_o.event_res = abas_pkg::EV_STALE;
        end else begin
          result_o.packet_checksum = held_checksum_q;
          if (ack_ok && (item_i.ack_seq == pending_seq_q)) begin
            result_o.event_res = abas_pkg::EV_ACCEPT;
            waiting_d = 1'b0;
            timer_d   = '0;
          end else begin
            result_o.event_res = abas_pkg::EV_DISCARD;
          end
        end
      end
      abas_pkg::KIND_TICK: begin
        if (waiting_q) begin
          if (timer_q <= TimeoutW'(1)) begin
            result_o.event_res       = abas_pkg::EV_RESEND;
            result_o.seq_bit         = pending_seq_q;
            result_o.packet_checksum = held_checksum_q;
            timer_d = timeout_i;
          end else begin
            timer_d = timer_q - TimeoutW'(1);
          end
        end
      end
      default: begin
        result_o.event_res = abas_pkg::EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q   <= '0;
      next_seq_q      <= 1'b0;
      waiting_q       <= 1'b0;
      pending_seq_q   <= 1'b0;
      held_checksum_q <= '0;
      timer_q         <= '0;
    end else if (step_i) begin
      running_sum_q   <= running_sum_d;
      next_seq_q      <= next_seq_d;
      waiting_q       <= waiting_d;
      pending_seq_q   <= pending_seq_d;
      held_checksum_q <= held_checksum_d;
      timer_q         <= timer_d;
    end
  end

  assign status_o.waiting     = waiting_q;
  assign status_o.pending_seq = pending_seq_q;

endmodule
`default_nettype wire

[sv/alternating_bit_arq_sender_top.sv]
// Alternating-bit ARQ sender: stream ports, input and result registers, APB register.
// Depends on abas_pkg, abas_core, alternating_bit_arq_sender_top_assert.svh.
//
// Stop-and-wait sender. Every accepted item yields exactly one result item:
// payload words build a one's complement sum, the last word emits a send with
// the sequence bit and checksum, acks with a good checksum and the pending
// sequence bit release the wait, and timer ticks count toward a resend; while
// waiting, words are refused as busy. The block accepts one item per cycle while
// the result output is not stalled. An accepted item is held in the input register
// until it is processed, and its result is then offered from the result register.
// A held result stalls on m_axis_tready without losing items. The timeout register
// is selected when paddr[2] is 0 and is loaded into the timer on each send or resend.
`default_nettype none
`include "alternating_bit_arq_sender_top_assert.svh"
module alternating_bit_arq_sender_top #(
  parameter int unsigned TimeoutW = abas_pkg::TimeoutW
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] data_word, [16] ack_seq, [56:17] ack_text, [59:57] ack_text_len,
  // [75:60] ack_checksum, [79:76] zero
  input  wire logic [79:0] s_axis_tdata,
  // [1:0] kind, [2] odd_last
  input  wire logic [2:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] seq_bit, [16:1] packet_checksum, [23:17] zero
  output logic [23:0]      m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]       m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                in_valid_q;
  abas_pkg::item_t     in_item_q;
  logic                out_valid_q;
  abas_pkg::result_t   out_res_q;
  abas_pkg::result_t   core_res;
  abas_pkg::status_t   status;
  logic [TimeoutW-1:0] timeout_q;
  logic                step;
  logic                in_load;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q.kind         <= s_axis_tuser[1:0];
      in_item_q.odd_last     <= s_axis_tuser[2];
      in_item_q.is_last      <= s_axis_tlast;
      in_item_q.data_word    <= s_axis_tdata[15:0];
      in_item_q.ack_seq      <= s_axis_tdata[16];
      in_item_q.ack_text     <= s_axis_tdata[56:17];
      in_item_q.ack_text_len <= s_axis_tdata[59:57];
      in_item_q.ack_checksum <= s_axis_tdata[75:60];
    end
  end

  abas_core #(
    .TimeoutW (TimeoutW)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .timeout_i (timeout_q),
    .result_o  (core_res),
    .status_o  (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.event_res;
  assign m_axis_tdata  = {7'd0, out_res_q.packet_checksum, out_res_q.seq_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutW'(abas_pkg::TIMEOUT_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == abas_pkg::REG_TIMEOUT)) begin
      timeout_q <= pwdata[TimeoutW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == abas_pkg::REG_TIMEOUT) ? 32'(timeout_q) : 32'd0;

  `ABAS_ASSERT(a_send_sets_wait, clk_i, rst_ni,
    step && (core_res.event_res == abas_pkg::EV_SEND) |=> status.waiting,
    "send did not enter the wait")
  `ABAS_ASSERT(a_accept_clears_wait, clk_i, rst_ni,
    step && (core_res.event_res == abas_pkg::EV_ACCEPT) |=> !status.waiting,
    "accepted ack did not release the wait")
  `ABAS_ASSERT_NEVER(a_busy_only_waiting, clk_i, rst_ni,
    step && (core_res.event_res == abas_pkg::EV_BUSY) && !status.waiting,
    "payload refused while not waiting")
  `ABAS_ASSERT(a_result_follows_step, clk_i, rst_ni,
    step |=> out_valid_q,
    "processed item produced no result")

endmodule
`default_nettype wire
